/* hdl/rrw_pkg.sv */
// rrw_pkg: shared constants, types and helper functions for the receive replay window
// no dependencies; used by the interfaces and every module of the block

package rrw_pkg;

	// window geometry
	localparam int WINDOW_BITS = 64;
	localparam int EXTEND_BACK = 16384;
	localparam int SEQ_W       = 16;
	localparam int HEAD_W      = 64;
	localparam int REL_W       = 18;
	localparam int SHIFT_W     = $clog2(WINDOW_BITS);

	localparam logic [HEAD_W-1:0] WIN_MASK   = {HEAD_W{1'b1}} >> (HEAD_W - WINDOW_BITS);
	localparam logic [HEAD_W-1:0] OLDER_MASK = WIN_MASK & ~HEAD_W'(16'hFFFF);

	localparam logic signed [REL_W-1:0] WIN_POS = REL_W'(WINDOW_BITS);
	localparam logic signed [REL_W-1:0] WIN_NEG = -WIN_POS;
	localparam logic signed [REL_W-1:0] REL_ONE = REL_W'(1);
	localparam logic [REL_W-1:0]        EXT_BACK_R = REL_W'(EXTEND_BACK);
	localparam logic [SEQ_W-1:0]        EXT_BACK_S = SEQ_W'(EXTEND_BACK);

	// request function codes
	localparam logic FUNC_PKT   = 1'b0;
	localparam logic FUNC_RESET = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		ST_RESET   = 3'd0,
		ST_JUMP    = 3'd1,
		ST_ADVANCE = 3'd2,
		ST_OOO     = 3'd3,
		ST_TOO_OLD = 3'd4,
		ST_DUP     = 3'd5
	} status_t;

	// extended sequence number and its distance from the head
	typedef struct packed {
		logic [HEAD_W-1:0]        full_seq;
		logic signed [REL_W-1:0]  rel;
	} ext_t;

	// window state
	typedef struct packed {
		logic [HEAD_W-1:0] head;
		logic [HEAD_W-1:0] bitmap;
	} win_t;

	// one result
	typedef struct packed {
		logic              accept;
		status_t           status;
		logic [HEAD_W-1:0] full_seq;
		logic [SEQ_W-1:0]  ack_seq;
		logic [SEQ_W-1:0]  ack_vec;
	} res_t;

	// bits 1..15 of the bitmap plus the all-older-received flag
	function automatic logic [SEQ_W-1:0] ack_vector(input logic [HEAD_W-1:0] bm);
		logic older;
		older = ((bm & OLDER_MASK) == OLDER_MASK);
		return {older, bm[15:1]};
	endfunction

endpackage

/* hdl/rrw_pkt_if.sv */
// rrw_pkt_if: request channel carrying one received packet header or protocol reset
// depends on rrw_pkg for field widths

interface rrw_pkt_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [rrw_pkg::SEQ_W-1:0]     seq_low;
	logic [rrw_pkg::HEAD_W-1:0]    new_head;

	modport source(output valid, func, seq_low, new_head, input ready);
	modport sink(input valid, func, seq_low, new_head, output ready);
endinterface

/* hdl/rrw_res_if.sv */
// rrw_res_if: result channel carrying the window decision and acknowledgement fields
// depends on rrw_pkg for field widths

interface rrw_res_if;
	logic                          valid;
	logic                          ready;
	logic                          accept;
	logic [2:0]                    status;
	logic [rrw_pkg::HEAD_W-1:0]    full_seq;
	logic [rrw_pkg::SEQ_W-1:0]     ack_seq;
	logic [rrw_pkg::SEQ_W-1:0]     ack_vec;

	modport source(output valid, accept, status, full_seq, ack_seq, ack_vec, input ready);
	modport sink(input valid, accept, status, full_seq, ack_seq, ack_vec, output ready);
endinterface

/* hdl/rrw_ext.sv */
// rrw_ext: extends a 16-bit wire sequence number to 64 bits around the current head
// depends on rrw_pkg

module rrw_ext (
	input  logic [rrw_pkg::SEQ_W-1:0]  seq_low,
	input  logic [rrw_pkg::HEAD_W-1:0] head,
	output rrw_pkg::ext_t              ext
);

	logic [rrw_pkg::SEQ_W-1:0] base_lo;
	logic [rrw_pkg::SEQ_W-1:0] off;
	logic signed [rrw_pkg::REL_W-1:0] rel;

	// offset from the bottom of the extension range, modulo 2^16
	assign base_lo = head[rrw_pkg::SEQ_W-1:0] - rrw_pkg::EXT_BACK_S;
	assign off     = seq_low - base_lo;

	// signed distance from the head
	assign rel = $signed(rrw_pkg::REL_W'(off) - rrw_pkg::EXT_BACK_R);

	assign ext.rel      = rel;
	assign ext.full_seq = head + {{(rrw_pkg::HEAD_W - rrw_pkg::REL_W){rel[rrw_pkg::REL_W-1]}}, rel};

endmodule

/* hdl/rrw_win.sv */
// rrw_win: window decision, next window state and acknowledgement fields for one request
// depends on rrw_pkg

module rrw_win (
	input  logic                        func,
	input  logic [rrw_pkg::HEAD_W-1:0]  new_head,
	input  rrw_pkg::ext_t               ext,
	input  rrw_pkg::win_t               cur,
	output rrw_pkg::win_t               nxt,
	output rrw_pkg::res_t               res
);

	logic [rrw_pkg::SHIFT_W-1:0] idx;
	logic signed [rrw_pkg::REL_W-1:0] neg_rel;

	assign neg_rel = -ext.rel;
	assign idx     = neg_rel[rrw_pkg::SHIFT_W-1:0];

	// reset, jump, shift or check the window
	always_comb begin
		nxt          = cur;
		res.accept   = 1'b1;
		res.status   = rrw_pkg::ST_RESET;
		res.full_seq = '0;
		if (func == rrw_pkg::FUNC_RESET) begin
			nxt.head   = new_head;
			nxt.bitmap = rrw_pkg::WIN_MASK;
		end else begin
			res.full_seq = ext.full_seq;
			if (ext.rel >= rrw_pkg::WIN_POS) begin
				nxt.head   = ext.full_seq;
				nxt.bitmap = rrw_pkg::HEAD_W'(1);
				res.status = rrw_pkg::ST_JUMP;
			end else if (ext.rel >= rrw_pkg::REL_ONE) begin
				nxt.head   = ext.full_seq;
				nxt.bitmap = ((cur.bitmap << ext.rel[rrw_pkg::SHIFT_W-1:0])
					& rrw_pkg::WIN_MASK) | rrw_pkg::HEAD_W'(1);
				res.status = rrw_pkg::ST_ADVANCE;
			end else if (ext.rel <= rrw_pkg::WIN_NEG) begin
				res.accept = 1'b0;
				res.status = rrw_pkg::ST_TOO_OLD;
			end else if (cur.bitmap[idx]) begin
				res.accept = 1'b0;
				res.status = rrw_pkg::ST_DUP;
			end else begin
				nxt.bitmap[idx] = 1'b1;
				res.status      = rrw_pkg::ST_OOO;
			end
		end
		// acknowledgement fields from the state after this request
		res.ack_seq = nxt.head[rrw_pkg::SEQ_W-1:0];
		res.ack_vec = rrw_pkg::ack_vector(nxt.bitmap);
	end

endmodule

/* hdl/rx_replay_window_with_ack_vector_core.sv */
// A request is held in the input register and then in the result register before its result is valid.
// Throughput: one request per cycle unless stalled; head/bitmap updates in the single result stage.
// A new request is taken while a finished result waits, as long as the input register is empty.
// Reset (arst_n low, asynchronous): head cleared to zero, bitmap all ones, both registers empty.
// rx_replay_window_with_ack_vector_core: top level; depends on rrw_pkg, rrw_pkt_if, rrw_res_if,
// rrw_ext and rrw_win

module rx_replay_window_with_ack_vector_core (
	input  logic      clk,
	input  logic      arst_n,
	rrw_pkt_if.sink   pkt,
	rrw_res_if.source res
);

	logic                          valid_s1;
	logic                          func_s1;
	logic [rrw_pkg::SEQ_W-1:0]     seq_s1;
	logic [rrw_pkg::HEAD_W-1:0]    new_head_s1;
	logic                          valid_s2;
	rrw_pkg::res_t                 res_s2;
	logic [rrw_pkg::HEAD_W-1:0]    head_q;
	logic [rrw_pkg::HEAD_W-1:0]    bitmap_q;
	logic                          advance;
	rrw_pkg::ext_t                 ext;
	rrw_pkg::win_t                 cur;
	rrw_pkg::win_t                 nxt;
	rrw_pkg::res_t                 res_d;

	// handshake: result register frees when empty or taken
	assign advance   = !valid_s2 || res.ready;
	assign pkt.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			func_s1     <= pkt.func;
			seq_s1      <= pkt.seq_low;
			new_head_s1 <= pkt.new_head;
		end
	end

	// sequence extension and window logic
	assign cur.head   = head_q;
	assign cur.bitmap = bitmap_q;

	rrw_ext u_ext (
		.seq_low (seq_s1),
		.head    (head_q),
		.ext     (ext)
	);

	rrw_win u_win (
		.func     (func_s1),
		.new_head (new_head_s1),
		.ext      (ext),
		.cur      (cur),
		.nxt      (nxt),
		.res      (res_d)
	);

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			bitmap_q <= rrw_pkg::WIN_MASK;
		end else if (valid_s1 && advance) begin
			head_q   <= nxt.head;
			bitmap_q <= nxt.bitmap;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_d;
		end
	end

	assign res.valid    = valid_s2;
	assign res.accept   = res_s2.accept;
	assign res.status   = res_s2.status;
	assign res.full_seq = res_s2.full_seq;
	assign res.ack_seq  = res_s2.ack_seq;
	assign res.ack_vec  = res_s2.ack_vec;

`ifndef SYNTHESIS
	// the head position is always marked as received
	a_bit0_set: assert property (@(posedge clk) disable iff (!arst_n)
		bitmap_q[0])
		else $error("bitmap bit 0 cleared");

	// a reset result is accepted and carries no sequence number
	a_reset_res: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == rrw_pkg::ST_RESET |->
			res_s2.accept && res_s2.full_seq == '0)
		else $error("reset result fields wrong");

	// drop decision agrees with status
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.accept ==
			(res_s2.status != rrw_pkg::ST_TOO_OLD && res_s2.status != rrw_pkg::ST_DUP)))
		else $error("accept flag disagrees with status");

	// a stalled request in the input register is kept
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(seq_s1) && $stable(func_s1))
		else $error("stalled request lost");

	// after a jump only the head is marked in the acknowledgement vector
	a_jump_ack: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == rrw_pkg::ST_JUMP |-> res_s2.ack_vec[14:0] == '0)
		else $error("jump left stale bitmap bits");
`endif

endmodule

/* verif/rrw_window_checker.sv */
`timescale 1ns / 1ps
// rrw_window_checker: watches both channels and predicts the window decision and ack fields
// depends on rrw_pkg, rrw_pkt_if and rrw_res_if

module rrw_window_checker (
	input  logic        clk,
	input  logic        arst_n,
	rrw_pkt_if          pkt,
	rrw_res_if          res,
	output int unsigned fail_count,
	output int unsigned pending
);
	import rrw_pkg::*;

	// predicted window state
	logic [HEAD_W-1:0] win_head;
	logic [HEAD_W-1:0] win_bits;

	res_t        ack_queue[$];
	res_t        want;
	int unsigned fails;

	// window update for one request, returns the ack result it should give
	function automatic res_t predict_ack(input logic f, input logic [SEQ_W-1:0] s,
			input logic [HEAD_W-1:0] h);
		res_t              r;
		logic [HEAD_W-1:0] base;
		logic [HEAD_W-1:0] bit_m;
		logic [SEQ_W-1:0]  off;
		int                rel;
		r.accept   = 1'b1;
		r.status   = ST_RESET;
		r.full_seq = '0;
		if (f == FUNC_RESET) begin
			win_head = h;
			win_bits = WIN_MASK;
		end else begin
			// extend the wire number into the range starting EXTEND_BACK below the head
			base       = win_head - HEAD_W'(EXTEND_BACK);
			off        = s - base[SEQ_W-1:0];
			rel        = int'(off) - EXTEND_BACK;
			r.full_seq = base + HEAD_W'(off);
			if (rel >= WINDOW_BITS) begin
				win_head = r.full_seq;
				win_bits = HEAD_W'(1);
				r.status = ST_JUMP;
			end else if (rel >= 1) begin
				win_bits = ((win_bits << rel) & WIN_MASK) | HEAD_W'(1);
				win_head = r.full_seq;
				r.status = ST_ADVANCE;
			end else if (rel <= -WINDOW_BITS) begin
				r.accept = 1'b0;
				r.status = ST_TOO_OLD;
			end else begin
				bit_m = HEAD_W'(1) << (-rel);
				if ((win_bits & bit_m) != '0) begin
					r.accept = 1'b0;
					r.status = ST_DUP;
				end else begin
					win_bits = win_bits | bit_m;
					r.status = ST_OOO;
				end
			end
		end
		// ack fields come from the state after the update
		r.ack_seq = win_head[SEQ_W-1:0];
		r.ack_vec = {((win_bits | ~OLDER_MASK) == '1), win_bits[15:1]};
		return r;
	endfunction

	task automatic check_field(input string name, input logic [HEAD_W-1:0] exp_v,
			input logic [HEAD_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			fails++;
		end
	endtask

	// compare results against the oldest prediction, then predict the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_head = '0;
			win_bits = WIN_MASK;
			ack_queue.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (ack_queue.size() == 0) begin
					$display("%0t: result with none expected: expected nothing, actual status %h seq %h",
						$time, res.status, res.full_seq);
					fails++;
				end else begin
					want = ack_queue.pop_front();
					check_field("accept", HEAD_W'(want.accept), HEAD_W'(res.accept));
					check_field("status", HEAD_W'(want.status), HEAD_W'(res.status));
					check_field("full_seq", want.full_seq, res.full_seq);
					check_field("ack_seq", HEAD_W'(want.ack_seq), HEAD_W'(res.ack_seq));
					check_field("ack_vec", HEAD_W'(want.ack_vec), HEAD_W'(res.ack_vec));
				end
			end
			if (pkt.valid && pkt.ready)
				ack_queue.push_back(predict_ack(pkt.func, pkt.seq_low, pkt.new_head));
			fail_count <= fails;
			pending <= ack_queue.size();
		end
	end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// tb: drives requests into rx_replay_window_with_ack_vector_core and gives the verdict
// depends on rrw_pkg, rrw_pkt_if, rrw_res_if, rrw_window_checker and the core

module tb;
	import rrw_pkg::*;

	localparam int N_RANDOM = 600;
	localparam int LIMIT    = 200000;

	logic        clk;
	logic        arst_n;
	logic        in_random;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles;

	// receiver's copy of the low head bits, used to aim requests at the window
	logic [SEQ_W-1:0] aim;

	rrw_pkt_if pkt_ch();
	rrw_res_if res_ch();

	rx_replay_window_with_ack_vector_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.res    (res_ch)
	);

	rrw_window_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// known values from time zero
	initial begin
		arst_n          = 1'b0;
		in_random       = 1'b0;
		pkt_ch.valid    = 1'b0;
		pkt_ch.func     = FUNC_PKT;
		pkt_ch.seq_low  = '0;
		pkt_ch.new_head = '0;
		res_ch.ready    = 1'b0;
		aim             = '0;
	end

	// offer one request and hold it until taken
	task automatic send(input logic f, input logic [SEQ_W-1:0] s, input logic [HEAD_W-1:0] h);
		logic [SEQ_W-1:0] off;
		int               rel;
		@(negedge clk);
		pkt_ch.valid    = 1'b1;
		pkt_ch.func     = f;
		pkt_ch.seq_low  = s;
		pkt_ch.new_head = h;
		@(posedge clk);
		while (!pkt_ch.ready)
			@(posedge clk);
		// follow the head so later requests land near the window
		if (f == FUNC_RESET) begin
			aim = h[SEQ_W-1:0];
		end else begin
			off = s - aim + SEQ_W'(EXTEND_BACK);
			rel = int'(off) - EXTEND_BACK;
			if (rel > 0)
				aim = s;
		end
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			@(negedge clk);
			pkt_ch.valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// receiver: shifting stall patterns plus one long hold-off during the random part
	initial begin
		int mode;
		int left;
		int hold_left;
		int since;
		bit held;
		mode      = 0;
		left      = 0;
		hold_left = 0;
		since     = 0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 120);
			end
			left--;
			if (hold_left > 0) begin
				res_ch.ready = 1'b0;
				hold_left--;
			end else begin
				if (in_random && !held) begin
					since++;
					if (since == 200) begin
						held      = 1'b1;
						hold_left = 300;
					end
				end
				case (mode)
					0: res_ch.ready = 1'b1;
					1: res_ch.ready = 1'($urandom_range(0, 1));
					2: res_ch.ready = ($urandom_range(0, 3) == 0);
					default: res_ch.ready = ((left % 5) != 0);
				endcase
			end
		end
	end

	// cycle limit
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("rx_replay_window_with_ack_vector_core test failed");
		$finish;
	end

	// stimulus and verdict
	initial begin
		int               n;
		int               burst;
		int               kind;
		logic [SEQ_W-1:0] s;
		logic [HEAD_W-1:0] h;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: each window outcome, range edges and head wrap
		send(FUNC_PKT, 16'd0, '1);                  // duplicate of head after reset
		send(FUNC_PKT, aim + 16'd5, '0);            // advance
		send(FUNC_PKT, aim - 16'd2, '0);            // out-of-order fill
		send(FUNC_PKT, aim - 16'd2, '0);            // duplicate
		send(FUNC_PKT, aim + 16'd95, '0);           // jump
		send(FUNC_PKT, aim - 16'd64, '0);           // just too old
		send(FUNC_PKT, aim - 16'd63, '0);           // oldest bit in window
		send(FUNC_PKT, aim + 16'd49151, '0);        // farthest forward jump
		send(FUNC_PKT, aim - 16'd16384, '0);        // farthest back
		send(FUNC_RESET, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF0);
		send(FUNC_PKT, aim + 16'd15, '0);           // head to all ones
		send(FUNC_PKT, aim + 16'd6, '0);            // head wraps past zero
		send(FUNC_RESET, 16'h0000, 64'h0);
		send(FUNC_PKT, 16'hFFFF, '0);               // below head zero, duplicate
		send(FUNC_PKT, 16'hC000, '0);               // back edge below head zero
		send(FUNC_RESET, 16'h1234, 64'hA5A5_5A5A_0123_4567);
		pause(3);
		send(FUNC_PKT, aim + 16'd63, '0);           // widest shift, older flag clears
		send(FUNC_PKT, aim + 16'd64, '0);           // narrowest jump
		send(FUNC_PKT, aim + 16'd1, '0);
		send(FUNC_PKT, aim - 16'd1, '0);            // duplicate after jump
		send(FUNC_PKT, aim - 16'd2, '0);            // hole after jump
		send(FUNC_RESET, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send(FUNC_PKT, 16'hFFFF, '0);
		send(FUNC_PKT, 16'h0000, '0);               // advance wraps head to zero
		pause(2);

		// random: mostly in-window traffic with a share of stale, jumps, resets and noise
		in_random = 1'b1;
		n = 0;
		while (n < N_RANDOM) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && n < N_RANDOM; i++) begin
				kind = $urandom_range(0, 99);
				h    = {$urandom, $urandom};
				if (kind < 38)
					send(FUNC_PKT, aim + SEQ_W'($urandom_range(1, 4)), h);
				else if (kind < 60)
					send(FUNC_PKT, aim - SEQ_W'($urandom_range(1, 63)), h);
				else if (kind < 68)
					send(FUNC_PKT, aim - SEQ_W'($urandom_range(0, 3)), h);
				else if (kind < 75)
					send(FUNC_PKT, aim - SEQ_W'($urandom_range(64, 16384)), h);
				else if (kind < 80)
					send(FUNC_PKT, aim + SEQ_W'($urandom_range(64, 49151)), h);
				else if (kind < 85)
					send(FUNC_PKT, aim + SEQ_W'($urandom_range(5, 63)), h);
				else if (kind < 90) begin
					case ($urandom_range(0, 3))
						0: h = '0;
						1: h = '1;
						default: ;
					endcase
					send(FUNC_RESET, SEQ_W'($urandom), h);
				end else
					send(FUNC_PKT, SEQ_W'($urandom), h);
				n++;
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
		end
		pause(1);

		// drain, then allow for the pipeline
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("rx_replay_window_with_ack_vector_core test passed");
		else
			$display("rx_replay_window_with_ack_vector_core test failed");
		$finish;
	end

endmodule
